// ===== rtl/core/rotation_matrix_to_euler_assert.svh =====
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles: assertion macros
// Shared concurrent assertion forms for the pipeline checks.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_EULER_ASSERT_SVH
`define ROTATION_MATRIX_TO_EULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RME_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle pipeline check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RME_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle pipeline check failed");

`endif

// ===== rtl/core/rme_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles: shared package
// CORDIC widths, binary-angle constants and the arctangent steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rme_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
  localparam int CORD_W       = 40;
  localparam int ANG_W        = 34;

  localparam logic [31:0] PIQ30 = 32'd3373259426;

  typedef logic signed [CORD_W-1:0] cord_t;
  typedef logic signed [ANG_W-1:0]  bam_t;

  localparam bam_t BAM_QUARTER = 34'sd1073741824;
  localparam bam_t BAM_HALF    = 34'sd2147483648;

  function automatic bam_t atan_bam(input int idx);
    bam_t v;
    case (idx)
      0:       v = 34'sh20000000;
      1:       v = 34'sh12E4051D;
      2:       v = 34'sh09FB385B;
      3:       v = 34'sh051111D4;
      4:       v = 34'sh028B0D43;
      5:       v = 34'sh0145D7E1;
      6:       v = 34'sh00A2F61E;
      7:       v = 34'sh00517C55;
      8:       v = 34'sh0028BE53;
      9:       v = 34'sh00145F2E;
      10:      v = 34'sh000A2F98;
      11:      v = 34'sh000517CC;
      12:      v = 34'sh00028BE6;
      13:      v = 34'sh000145F3;
      14:      v = 34'sh0000A2F9;
      15:      v = 34'sh0000517C;
      16:      v = 34'sh000028BE;
      17:      v = 34'sh0000145F;
      18:      v = 34'sh00000A2F;
      19:      v = 34'sh00000517;
      20:      v = 34'sh0000028B;
      21:      v = 34'sh00000145;
      22:      v = 34'sh000000A2;
      23:      v = 34'sh00000051;
      24:      v = 34'sh00000028;
      25:      v = 34'sh00000014;
      26:      v = 34'sh0000000A;
      27:      v = 34'sh00000005;
      28:      v = 34'sh00000002;
      29:      v = 34'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/rme_cordic.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles: vectoring CORDIC
// Pipelined atan2 with one rotation per stage, giving a binary angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rme_cordic (
  input  logic          clk,
  input  logic          en,
  input  rme_pkg::cord_t y_in,
  input  rme_pkg::cord_t x_in,
  output rme_pkg::bam_t  angle_out
);
  import rme_pkg::*;

  cord_t x_r   [CORDIC_STEPS+1];
  cord_t y_r   [CORDIC_STEPS+1];
  bam_t  acc_r [CORDIC_STEPS+1];
  logic  byp_r [CORDIC_STEPS+1];

  cord_t x_nxt;
  cord_t y_nxt;
  bam_t  acc_nxt;
  logic  byp_nxt;

  // Axis-aligned vectors are resolved up front; the left half plane is
  // turned by a quarter so the rotations only cover the right half.
  always_comb begin
    x_nxt   = x_in;
    y_nxt   = y_in;
    acc_nxt = '0;
    byp_nxt = 1'b0;
    if (y_in == 0) begin
      byp_nxt = 1'b1;
      acc_nxt = (x_in < 0) ? BAM_HALF : '0;
    end else if (x_in == 0) begin
      byp_nxt = 1'b1;
      acc_nxt = (y_in > 0) ? BAM_QUARTER : -BAM_QUARTER;
    end else if (x_in < 0) begin
      if (y_in >= 0) begin
        x_nxt   = y_in;
        y_nxt   = -x_in;
        acc_nxt = BAM_QUARTER;
      end else begin
        x_nxt   = -y_in;
        y_nxt   = x_in;
        acc_nxt = -BAM_QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= x_nxt;
      y_r[0]   <= y_nxt;
      acc_r[0] <= acc_nxt;
      byp_r[0] <= byp_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cord_t dx;
    cord_t dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        byp_r[i+1] <= byp_r[i];
        if (byp_r[i]) begin
          x_r[i+1]   <= x_r[i];
          y_r[i+1]   <= y_r[i];
          acc_r[i+1] <= acc_r[i];
        end else if (y_r[i] >= 0) begin
          x_r[i+1]   <= x_r[i] + dx;
          y_r[i+1]   <= y_r[i] - dy;
          acc_r[i+1] <= acc_r[i] + atan_bam(i);
        end else begin
          x_r[i+1]   <= x_r[i] - dx;
          y_r[i+1]   <= y_r[i] + dy;
          acc_r[i+1] <= acc_r[i] - atan_bam(i);
        end
      end
    end
  end

  assign angle_out = acc_r[CORDIC_STEPS];

endmodule

// ===== rtl/core/rotation_matrix_to_euler.sv =====
// QS = ceil((P_W - IN_FRAC_BITS) / 2) is the step count of the quantizer square root.
// The pipelined square roots and the 30 CORDIC rotations each take one stage per step.
// Throughput: one item per cycle; the whole pipeline holds when the output stalls.
// Reset: synchronous, active low, clears the valid bits only.
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles
// Quantized quaternion and roll, pitch, yaw from a Q2.14 rotation matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rotation_matrix_to_euler_assert.svh"

module rotation_matrix_to_euler #(
  parameter int IN_FRAC_BITS    = 14,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_m00,
  input  logic signed [15:0] in_m01,
  input  logic signed [15:0] in_m02,
  input  logic signed [15:0] in_m10,
  input  logic signed [15:0] in_m11,
  input  logic signed [15:0] in_m12,
  input  logic signed [15:0] in_m20,
  input  logic signed [15:0] in_m21,
  input  logic signed [15:0] in_m22,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         out_quat_w,
  output logic signed [7:0]  out_quat_x,
  output logic signed [7:0]  out_quat_y,
  output logic signed [7:0]  out_quat_z,
  output logic signed [15:0] out_roll_angle,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle
);
  import rme_pkg::*;

  localparam int S_W    = ((IN_FRAC_BITS > 16) ? IN_FRAC_BITS : 16) + 3;
  localparam int P_W    = S_W - 1 + 14;
  localparam int Q_W    = P_W - IN_FRAC_BITS;
  localparam int QS     = (Q_W + 1) / 2;
  localparam int QE     = 2 * QS;
  localparam int PS     = 29;
  localparam int PE     = 2 * PS;
  localparam int LAT    = 10 + QS + PS + CORDIC_LAT;
  localparam int MAG_W  = ANG_W - 1;
  localparam int LO_W   = 17;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int SH     = 61 - ANGLE_FRAC_BITS;
  localparam int RAD_W  = 66 - SH;

  localparam logic [65:0] RND       = 66'(1) << (SH - 1);
  localparam logic [65:0] PI_FULL   = ((66'(1) << 31) * 66'(PIQ30) + RND) >> SH;
  localparam logic [65:0] HALF_FULL = ((66'(1) << 30) * 66'(PIQ30) + RND) >> SH;
  localparam logic [RAD_W-1:0] PI_LIM   = PI_FULL[RAD_W-1:0];
  localparam logic [RAD_W-1:0] HALF_LIM = HALF_FULL[RAD_W-1:0];

  localparam logic [13:0] QUANT_SCALE = 14'd10000;
  localparam int          QUANT_MAX   = 100;
  localparam logic [24:0] ASIN_RAD2   = 25'd25000000;

  typedef logic signed [S_W-1:0] sum_t;
  localparam sum_t ONE = sum_t'(1) << IN_FRAC_BITS;

  typedef struct packed {
    logic [6:0]        w;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic signed [7:0] z;
  } quat_t;

  typedef struct packed {
    quat_t              q;
    logic signed [17:0] roll_y;
    logic signed [17:0] roll_x;
    logic signed [17:0] yaw_y;
    logic signed [17:0] yaw_x;
    logic signed [16:0] p;
    logic               sat_hi;
    logic               sat_lo;
  } mid_t;

  typedef struct packed {
    quat_t q;
    logic  sat_hi;
    logic  sat_lo;
  } tail_t;

  logic           adv;
  logic [LAT-1:0] vld_r;

  assign adv       = !vld_r[LAT-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  sum_t              s_c   [4];
  logic signed [16:0] dx_c;
  logic signed [16:0] dy_c;
  logic signed [16:0] dz_c;
  logic [S_W-2:0]    s_r   [4];
  logic              neg_r [4];

  assign s_c[0] = ONE + sum_t'(in_m00) + sum_t'(in_m11) + sum_t'(in_m22);
  assign s_c[1] = ONE + sum_t'(in_m00) - sum_t'(in_m11) - sum_t'(in_m22);
  assign s_c[2] = ONE - sum_t'(in_m00) + sum_t'(in_m11) - sum_t'(in_m22);
  assign s_c[3] = ONE - sum_t'(in_m00) - sum_t'(in_m11) + sum_t'(in_m22);
  assign dx_c   = 17'(in_m21) - 17'(in_m12);
  assign dy_c   = 17'(in_m02) - 17'(in_m20);
  assign dz_c   = 17'(in_m10) - 17'(in_m01);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        s_r[l] <= (s_c[l] < 0) ? '0 : s_c[l][S_W-2:0];
      end
      neg_r[0] <= 1'b0;
      neg_r[1] <= dx_c < 0;
      neg_r[2] <= dy_c < 0;
      neg_r[3] <= dz_c < 0;
    end
  end

  logic [QE:0] qiv_r  [QS+1][4];
  logic [QE:0] qir_r  [QS+1][4];
  logic        qneg_r [QS+1][4];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [P_W-1:0] prod;
    assign prod = P_W'(s_r[l]) * P_W'(QUANT_SCALE);
    always_ff @(posedge clk) begin
      if (adv) begin
        qiv_r[0][l]  <= (QE+1)'(prod[P_W-1:IN_FRAC_BITS]);
        qir_r[0][l]  <= '0;
        qneg_r[0][l] <= neg_r[l];
      end
    end
    for (genvar j = 0; j < QS; j++) begin : g_sq
      localparam logic [QE:0] BIT = (QE+1)'(1) << (QE - 2 - 2 * j);
      logic [QE:0] t;
      assign t = qir_r[j][l] + BIT;
      always_ff @(posedge clk) begin
        if (adv) begin
          qneg_r[j+1][l] <= qneg_r[j][l];
          if (qiv_r[j][l] >= t) begin
            qiv_r[j+1][l] <= qiv_r[j][l] - t;
            qir_r[j+1][l] <= (qir_r[j][l] >> 1) + BIT;
          end else begin
            qiv_r[j+1][l] <= qiv_r[j][l];
            qir_r[j+1][l] <= qir_r[j][l] >> 1;
          end
        end
      end
    end
  end

  logic [QS-1:0]     qu [4];
  logic [QS:0]       qk [4];
  logic signed [7:0] qq [4];
  quat_t             qt_r;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      qu[l] = qir_r[QS][l][QS-1:0];
      if (!qneg_r[QS][l]) begin
        qk[l] = ({1'b0, qu[l]} + 1'b1) >> 1;
      end else if (qu[l] != '0) begin
        qk[l] = ({1'b0, qu[l]} - 1'b1) >> 1;
      end else begin
        qk[l] = '0;
      end
      if (qk[l] > (QS+1)'(QUANT_MAX)) begin
        qq[l] = qneg_r[QS][l] ? -8'(QUANT_MAX) : 8'(QUANT_MAX);
      end else begin
        qq[l] = qneg_r[QS][l] ? -$signed(8'(qk[l])) : $signed(8'(qk[l]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qt_r.w <= qq[0][6:0];
      qt_r.x <= qq[1];
      qt_r.y <= qq[2];
      qt_r.z <= qq[3];
    end
  end

  logic signed [7:0]  qw_s;
  quat_t              qm_r;
  logic signed [15:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;

  assign qw_s = $signed({1'b0, qt_r.w});

  always_ff @(posedge clk) begin
    if (adv) begin
      qm_r <= qt_r;
      wx_r <= qw_s * qt_r.x;
      yz_r <= qt_r.y * qt_r.z;
      xx_r <= qt_r.x * qt_r.x;
      yy_r <= qt_r.y * qt_r.y;
      wz_r <= qw_s * qt_r.z;
      xy_r <= qt_r.x * qt_r.y;
      zz_r <= qt_r.z * qt_r.z;
      wy_r <= qw_s * qt_r.y;
      zx_r <= qt_r.z * qt_r.x;
    end
  end

  mid_t               mid_nxt;
  mid_t               mid_r [PS+3];
  logic signed [33:0] psq_c;
  logic [28:0]        psq_r;
  logic [24:0]        dsq_c;
  logic [PE:0]        piv_r [PS+1];
  logic [PE:0]        pir_r [PS+1];

  always_comb begin
    mid_nxt.q      = qm_r;
    mid_nxt.roll_y = (18'(wx_r) + 18'(yz_r)) <<< 1;
    mid_nxt.roll_x = 18'sd10000 - ((18'(xx_r) + 18'(yy_r)) <<< 1);
    mid_nxt.yaw_y  = (18'(wz_r) + 18'(xy_r)) <<< 1;
    mid_nxt.yaw_x  = 18'sd10000 - ((18'(yy_r) + 18'(zz_r)) <<< 1);
    mid_nxt.p      = 17'(wy_r) - 17'(zx_r);
    mid_nxt.sat_hi = mid_nxt.p >= 17'sd5000;
    mid_nxt.sat_lo = mid_nxt.p <= -17'sd5000;
  end

  assign psq_c = 34'(mid_r[0].p) * 34'(mid_r[0].p);
  assign dsq_c = (29'(ASIN_RAD2) > psq_r) ? (ASIN_RAD2 - psq_r[24:0]) : '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      mid_r[0] <= mid_nxt;
      for (int k = 1; k < PS + 3; k++) begin
        mid_r[k] <= mid_r[k-1];
      end
      psq_r    <= psq_c[28:0];
      piv_r[0] <= {2'b00, dsq_c, 32'd0};
      pir_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < PS; j++) begin : g_psq
    localparam logic [PE:0] BIT = (PE+1)'(1) << (PE - 2 - 2 * j);
    logic [PE:0] t;
    assign t = pir_r[j] + BIT;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (piv_r[j] >= t) begin
          piv_r[j+1] <= piv_r[j] - t;
          pir_r[j+1] <= (pir_r[j] >> 1) + BIT;
        end else begin
          piv_r[j+1] <= piv_r[j];
          pir_r[j+1] <= pir_r[j] >> 1;
        end
      end
    end
  end

  cord_t cy  [3];
  cord_t cx  [3];
  bam_t  ang [3];
  tail_t tl_r [CORDIC_LAT];

  assign cy[0] = cord_t'(mid_r[PS+2].roll_y) <<< 20;
  assign cx[0] = cord_t'(mid_r[PS+2].roll_x) <<< 20;
  assign cy[1] = cord_t'(mid_r[PS+2].p) <<< 16;
  assign cx[1] = cord_t'({1'b0, pir_r[PS][PS-1:0]});
  assign cy[2] = cord_t'(mid_r[PS+2].yaw_y) <<< 20;
  assign cx[2] = cord_t'(mid_r[PS+2].yaw_x) <<< 20;

  always_ff @(posedge clk) begin
    if (adv) begin
      tl_r[0].q      <= mid_r[PS+2].q;
      tl_r[0].sat_hi <= mid_r[PS+2].sat_hi;
      tl_r[0].sat_lo <= mid_r[PS+2].sat_lo;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        tl_r[k] <= tl_r[k-1];
      end
    end
  end

  rme_cordic u_cordic_roll (
    .clk       (clk),
    .en        (adv),
    .y_in      (cy[0]),
    .x_in      (cx[0]),
    .angle_out (ang[0])
  );

  rme_cordic u_cordic_pitch (
    .clk       (clk),
    .en        (adv),
    .y_in      (cy[1]),
    .x_in      (cx[1]),
    .angle_out (ang[1])
  );

  rme_cordic u_cordic_yaw (
    .clk       (clk),
    .en        (adv),
    .y_in      (cy[2]),
    .x_in      (cx[2]),
    .angle_out (ang[2])
  );

  quat_t                  t1q_r;
  quat_t                  t2q_r;
  logic [LO_W+31:0]       lo_r   [3];
  logic [HI_W+31:0]       hi_r   [3];
  logic                   sg1_r  [3];
  logic                   sg2_r  [3];
  logic [RAD_W-1:0]       mag2_r [3];
  logic signed [RAD_W:0]  sv     [3];

  for (genvar l = 0; l < 3; l++) begin : g_rad
    localparam logic [RAD_W-1:0] LIM = (l == 1) ? HALF_LIM : PI_LIM;
    bam_t             bsel;
    logic [ANG_W-1:0] babs;
    logic [65:0]      sum;
    logic [65:0]      rv;

    always_comb begin
      bsel = ang[l];
      if (l == 1) begin
        if (tl_r[CORDIC_LAT-1].sat_hi) begin
          bsel = BAM_QUARTER;
        end else if (tl_r[CORDIC_LAT-1].sat_lo) begin
          bsel = -BAM_QUARTER;
        end
      end
      babs = (bsel < 0) ? ANG_W'(-bsel) : ANG_W'(bsel);
    end

    assign sum = (66'(hi_r[l]) << LO_W) + 66'(lo_r[l]) + RND;
    assign rv  = sum >> SH;
    assign sv[l] = sg2_r[l] ? -$signed({1'b0, mag2_r[l]}) : $signed({1'b0, mag2_r[l]});

    always_ff @(posedge clk) begin
      if (adv) begin
        sg1_r[l]  <= bsel < 0;
        lo_r[l]   <= (LO_W+32)'(babs[LO_W-1:0]) * (LO_W+32)'(PIQ30);
        hi_r[l]   <= (HI_W+32)'(babs[MAG_W-1:LO_W]) * (HI_W+32)'(PIQ30);
        sg2_r[l]  <= sg1_r[l];
        mag2_r[l] <= (rv > 66'(LIM)) ? LIM : rv[RAD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1q_r           <= tl_r[CORDIC_LAT-1].q;
      t2q_r           <= t1q_r;
      out_quat_w      <= t2q_r.w;
      out_quat_x      <= t2q_r.x;
      out_quat_y      <= t2q_r.y;
      out_quat_z      <= t2q_r.z;
      out_roll_angle  <= 16'(sv[0]);
      out_pitch_angle <= 15'(sv[1]);
      out_yaw_angle   <= 16'(sv[2]);
    end
  end

  `RME_ASSERT_NXT(a_accept_enters, clk, rst_n, in_valid && in_ready, vld_r[0])
  `RME_ASSERT_NXT(a_stall_holds, clk, rst_n, !adv, vld_r == $past(vld_r))
  `RME_ASSERT_IMP(a_quat_w_range, clk, rst_n, out_valid, out_quat_w <= 7'd100)
  `RME_ASSERT_IMP(a_quat_x_range, clk, rst_n, out_valid, out_quat_x <= 8'sd100 && out_quat_x >= -8'sd100)

endmodule
